// File: hdl/tsw_pkg.sv
// ============================================================================
// Texture sampler package
// Shared types and constants of the wrapping bilinear texture sampler.
// ============================================================================
package tsw_pkg;

    // Default store dimensions, handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // Field and register widths.
    localparam int COORD_W    = 32;
    localparam int TEXEL_W    = 32;
    localparam int TXY_W      = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int SIZE_W     = 8;
    localparam int WGT_W      = 8;

    // Wrapped coordinate is 1.16 fixed point, the scaled one 9.16.
    localparam int T_W        = 17;
    localparam int P_W        = T_W + SIZE_W;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // Register reset values.
    localparam logic [SIZE_W-1:0] RST_SIZE = 8'd128;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP   = 2'd0,
        CFG_FILTER = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    // Request kinds.
    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    // Wrap and filter modes.
    typedef enum logic {
        WRAP_REPEAT = 1'b0,
        WRAP_CLAMP  = 1'b1
    } t_wrap;

    typedef enum logic {
        FILT_POINT    = 1'b0,
        FILT_BILINEAR = 1'b1
    } t_filter;

    // Effective configuration, sizes already limited to the store.
    typedef struct packed {
        t_wrap               wrap_mode;
        t_filter             filter_mode;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
    } t_cfg;

    // Store address selection.
    typedef enum logic [2:0] {
        ADDR_WRITE = 3'd0,
        ADDR_00    = 3'd1,
        ADDR_10    = 3'd2,
        ADDR_01    = 3'd3,
        ADDR_11    = 3'd4
    } t_addr_sel;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_BOT,
        ST_OUT,
        ST_PT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      wr_en;
        logic      load;
        logic      scale;
        t_addr_sel addr_sel;
        logic      cap_s0;
        logic      mk_top;
        logic      mk_bot;
        logic      out_point;
        logic      out_blend;
    } t_cmd;

endpackage

// File: hdl/tsw_cfg.sv
// ============================================================================
// Texture sampler configuration registers
// Holds wrap mode, filter mode and texture size, and limits the sizes to the
// range that the store supports.
// ============================================================================
module tsw_cfg import tsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic              r_wrap;
    logic              r_filter;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap   <= WRAP_CLAMP;
            r_filter <= FILT_BILINEAR;
            r_width  <= RST_SIZE;
            r_height <= RST_SIZE;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WRAP:   r_wrap   <= i_cfg_data[0];
                CFG_FILTER: r_filter <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, anything above the store as its edge.
    always_comb begin
        o_cfg.wrap_mode   = t_wrap'(r_wrap);
        o_cfg.filter_mode = t_filter'(r_filter);

        if (r_width == '0) begin
            o_cfg.width = SIZE_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            o_cfg.width = SIZE_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end

        if (r_height == '0) begin
            o_cfg.height = SIZE_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            o_cfg.height = SIZE_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end
    end

endmodule

// File: hdl/tsw_ctrl.sv
// ============================================================================
// Texture sampler controller
// Sequences a sample: scaling, one read if point, else four reads and blends.
// ============================================================================
module tsw_ctrl import tsw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_req_type,
    input  t_cfg  i_cfg,
    output logic  busy,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_00;
        busy           = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                busy           = 1'b0;
                o_cmd.addr_sel = ADDR_WRITE;
                if (start) begin
                    if (t_req'(i_req_type) == REQ_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_RD0;
            end
            ST_RD0: begin
                o_cmd.addr_sel = ADDR_00;
                if (i_cfg.filter_mode == FILT_POINT) begin
                    n_state = ST_PT;
                end else begin
                    n_state = ST_RD1;
                end
            end
            ST_RD1: begin
                o_cmd.addr_sel = ADDR_10;
                o_cmd.cap_s0   = 1'b1;
                n_state        = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.addr_sel = ADDR_01;
                o_cmd.mk_top   = 1'b1;
                n_state        = ST_RD3;
            end
            ST_RD3: begin
                o_cmd.addr_sel = ADDR_11;
                o_cmd.cap_s0   = 1'b1;
                n_state        = ST_BOT;
            end
            ST_BOT: begin
                o_cmd.mk_bot = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.out_blend = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_PT: begin
                o_cmd.out_point = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/tsw_dp.sv
// ============================================================================
// Texture sampler datapath
// Texel store, coordinate wrap and scale, neighbor addressing and the
// per-channel horizontal and vertical blends.
// ============================================================================
module tsw_dp import tsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  t_cfg                      i_cfg,
    input  logic [TXY_W-1:0]          i_texel_x,
    input  logic [TXY_W-1:0]          i_texel_y,
    input  logic [TEXEL_W-1:0]        i_texel_value,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    output logic [TEXEL_W-1:0]        o_color_out,
    output logic                      o_valid
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HB_W   = 16;
    localparam int VB_W   = HB_W + WGT_W + 1;

    // Wrap a 16.16 coordinate into 0..1.
    function automatic logic [T_W-1:0] wrap_coord(input t_wrap mode,
                                                  input logic [COORD_W-1:0] raw);
        logic [T_W-1:0] t;
        if (mode == WRAP_REPEAT) begin
            t = {1'b0, raw[15:0]};
        end else if (raw[COORD_W-1]) begin
            t = '0;
        end else if (raw > COORD_W'(T_ONE)) begin
            t = T_ONE;
        end else begin
            t = raw[T_W-1:0];
        end
        return t;
    endfunction

    // Horizontal blend of two texels, four 16-bit channel sums.
    function automatic logic [4*HB_W-1:0] hblend(input logic [TEXEL_W-1:0] a,
                                                 input logic [TEXEL_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
        logic [4*HB_W-1:0] s;
        logic [WGT_W:0]    wi;
        s  = '0;
        wi = 9'd256 - {1'b0, w};
        for (int ch = 0; ch < 4; ch++) begin
            s[ch*HB_W +: HB_W] = HB_W'(a[ch*8 +: 8] * wi) + HB_W'(b[ch*8 +: 8] * w);
        end
        return s;
    endfunction

    // Vertical blend of two channel sums into a packed texel.
    function automatic logic [TEXEL_W-1:0] vblend(input logic [4*HB_W-1:0] t,
                                                  input logic [4*HB_W-1:0] b,
                                                  input logic [WGT_W-1:0] w);
        logic [TEXEL_W-1:0] c;
        logic [WGT_W:0]     wi;
        logic [VB_W-1:0]    v;
        c  = '0;
        wi = 9'd256 - {1'b0, w};
        for (int ch = 0; ch < 4; ch++) begin
            v = VB_W'(t[ch*HB_W +: HB_W] * wi) + VB_W'(b[ch*HB_W +: HB_W] * w);
            c[ch*8 +: 8] = v[23:16];
        end
        return c;
    endfunction

    logic [TEXEL_W-1:0]     r_mem [DEPTH];
    logic [TEXEL_W-1:0]     r_rdata;
    logic [COORD_W-1:0]     r_u;
    logic [COORD_W-1:0]     r_v;
    logic [SIZE_W-1:0]      r_ix;
    logic [SIZE_W-1:0]      r_iy;
    logic [WGT_W-1:0]       r_wx;
    logic [WGT_W-1:0]       r_wy;
    logic [TEXEL_W-1:0]     r_s0;
    logic [4*HB_W-1:0]      r_top;
    logic [4*HB_W-1:0]      r_bot;
    logic [TEXEL_W-1:0]     r_color;
    logic                   r_valid;

    logic [T_W-1:0]         tu;
    logic [T_W-1:0]         tv;
    logic [P_W-1:0]         pu;
    logic [P_W-1:0]         pv;
    logic [SIZE_W-1:0]      wm1;
    logic [SIZE_W-1:0]      hm1;
    logic [SIZE_W-1:0]      nx;
    logic [SIZE_W-1:0]      ny;
    logic [SIZE_W-1:0]      sel_x;
    logic [SIZE_W-1:0]      sel_y;
    logic [ADDR_W-1:0]      addr;
    logic                   wr_ok;

    // Wrap and scale the latched coordinates by size minus one.
    always_comb begin
        wm1 = i_cfg.width - SIZE_W'(1);
        hm1 = i_cfg.height - SIZE_W'(1);
        tu  = wrap_coord(i_cfg.wrap_mode, r_u);
        tv  = wrap_coord(i_cfg.wrap_mode, r_v);
        pu  = P_W'(tu) * P_W'(wm1);
        pv  = P_W'(tv) * P_W'(hm1);
    end

    // Right and lower neighbors stop at the last column and row.
    always_comb begin
        if ({1'b0, r_ix} + 9'd1 < {1'b0, wm1}) begin
            nx = r_ix + SIZE_W'(1);
        end else begin
            nx = wm1;
        end
        if ({1'b0, r_iy} + 9'd1 < {1'b0, hm1}) begin
            ny = r_iy + SIZE_W'(1);
        end else begin
            ny = hm1;
        end
    end

    // Store address: the write position or one of the four sample texels.
    always_comb begin
        sel_x = r_ix;
        sel_y = r_iy;
        addr  = ADDR_W'(i_texel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(i_texel_x);
        unique case (i_cmd.addr_sel)
            ADDR_WRITE: ;
            ADDR_00: begin
                sel_x = r_ix;
                sel_y = r_iy;
            end
            ADDR_10: begin
                sel_x = nx;
                sel_y = r_iy;
            end
            ADDR_01: begin
                sel_x = r_ix;
                sel_y = ny;
            end
            ADDR_11: begin
                sel_x = nx;
                sel_y = ny;
            end
            default: ;
        endcase
        if (i_cmd.addr_sel != ADDR_WRITE) begin
            addr = ADDR_W'(sel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sel_x);
        end
        wr_ok = i_cmd.wr_en && (32'(i_texel_x) < MAX_WIDTH)
                && (32'(i_texel_y) < MAX_HEIGHT);
    end

    // Single-port texel store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[addr] <= i_texel_value;
        end
        r_rdata <= r_mem[addr];
    end

    // Coordinates, base texel, weights and blend terms.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= i_u_coord;
            r_v <= i_v_coord;
        end
        if (i_cmd.scale) begin
            r_ix <= pu[P_W-2:16];
            r_iy <= pv[P_W-2:16];
            r_wx <= pu[15:8];
            r_wy <= pv[15:8];
        end
        if (i_cmd.cap_s0) begin
            r_s0 <= r_rdata;
        end
        if (i_cmd.mk_top) begin
            r_top <= hblend(r_s0, r_rdata, r_wx);
        end
        if (i_cmd.mk_bot) begin
            r_bot <= hblend(r_s0, r_rdata, r_wx);
        end
        if (i_cmd.out_point) begin
            r_color <= r_rdata;
        end else if (i_cmd.out_blend) begin
            r_color <= vblend(r_top, r_bot, r_wy);
        end
    end

    // Result strobe lasts one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_point || i_cmd.out_blend;
        end
    end

    assign o_color_out = r_color;
    assign o_valid     = r_valid;

endmodule

// File: hdl/texture_sampler_wrap_bilinear.sv
// ============================================================================
// Wrapping bilinear texture sampler
// Texel store of packed RGBA8 words with point or bilinear sampling of
// signed 16.16 coordinates under repeat or clamp wrapping.
// ============================================================================
// A transaction is accepted when start is high while busy is low. A texel
// write takes effect at that edge, produces no result and leaves busy low, so
// writes may come every cycle. A point sample holds busy high through its
// scale, read and point-output states, a bilinear sample through its scale,
// four read, lower-blend and blend-output states; each shows its color as
// busy falls. A bilinear sample reads its four texels one per cycle through
// the single port of the store and blends them as they come. The color is
// shown with o_valid for exactly one cycle and cannot be held off, and a new
// transaction may be accepted in that same cycle. The store needs no clearing
// after reset; a sample must only touch texels that were written before.
module texture_sampler_wrap_bilinear import tsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [TXY_W-1:0]          i_texel_x,
    input  logic [TXY_W-1:0]          i_texel_y,
    input  logic [TEXEL_W-1:0]        i_texel_value,
    input  logic signed [COORD_W-1:0] i_u_coord,
    input  logic signed [COORD_W-1:0] i_v_coord,
    output logic [TEXEL_W-1:0]        o_color_out,
    output logic                      o_valid,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;

    // Configuration registers.
    tsw_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencer.
    tsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_cfg      (cfg),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    // Store and arithmetic.
    tsw_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_texel_x     (i_texel_x),
        .i_texel_y     (i_texel_y),
        .i_texel_value (i_texel_value),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .o_color_out   (o_color_out),
        .o_valid       (o_valid)
    );

endmodule

// File: tb/texture_sampler_wrap_bilinear_tb.sv
// ============================================================================
// Texture sampler testbench
// Self-checking bench for the wrapping bilinear texture sampler. A short
// stimulus plan walks the edges of coordinates, sizes and both modes, then
// random phases under changing settings mix texel writes with samples. Every
// sample is checked against a stated color or a behavioral copy of the texel
// store and the sampling arithmetic kept inside the bench.
// ============================================================================
module texture_sampler_wrap_bilinear_tb;
    import tsw_pkg::*;

    localparam int unsigned STORE_W     = DEF_MAX_WIDTH;
    localparam int unsigned STORE_H     = DEF_MAX_HEIGHT;
    localparam int unsigned STORE_DEPTH = STORE_W * STORE_H;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 110;
    localparam int unsigned PLAN_ROWS   = 20;

    // One row of the directed plan. A row may carry new settings, applied
    // before its transaction, and a color that is known without computation.
    typedef struct packed {
        logic                set_cfg;
        t_wrap               wrap;
        t_filter             filt;
        logic [SIZE_W-1:0]   wd;
        logic [SIZE_W-1:0]   ht;
        t_req                kind;
        logic [TXY_W-1:0]    tx;
        logic [TXY_W-1:0]    ty;
        logic [TEXEL_W-1:0]  texel;
        logic [COORD_W-1:0]  u;
        logic [COORD_W-1:0]  v;
        logic                fixed;
        logic [TEXEL_W-1:0]  color;
    } t_plan_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_req_type;
    logic [TXY_W-1:0]          i_texel_x;
    logic [TXY_W-1:0]          i_texel_y;
    logic [TEXEL_W-1:0]        i_texel_value;
    logic signed [COORD_W-1:0] i_u_coord;
    logic signed [COORD_W-1:0] i_v_coord;
    logic [TEXEL_W-1:0]        o_color_out;
    logic                      o_valid;
    logic                      i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    // Mirror of the texel store and of the settings.
    logic [TEXEL_W-1:0] texel_mirror [STORE_DEPTH];
    bit                 texel_set    [STORE_DEPTH];
    t_wrap              cur_wrap;
    t_filter            cur_filter;
    logic [SIZE_W-1:0]  cur_width;
    logic [SIZE_W-1:0]  cur_height;

    // Colors owed by the block, oldest first.
    logic [TEXEL_W-1:0] color_due [$];

    t_plan_row   directed_plan [PLAN_ROWS];
    bit          sender_gaps;
    int unsigned sent_count;
    int unsigned write_count;
    int unsigned sample_count;
    int unsigned compared_count;
    int unsigned settings_count;
    int unsigned fail_count;

    texture_sampler_wrap_bilinear u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_texel_x    (i_texel_x),
        .i_texel_y    (i_texel_y),
        .i_texel_value(i_texel_value),
        .i_u_coord    (i_u_coord),
        .i_v_coord    (i_v_coord),
        .o_color_out  (o_color_out),
        .o_valid      (o_valid),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // A register value of 0 behaves as 1, anything past the store as its size.
    function automatic int unsigned eff_dim(logic [SIZE_W-1:0] raw, int unsigned limit);
        if (raw == 0) return 1;
        if (32'(raw) > limit) return limit;
        return 32'(raw);
    endfunction

    // Bring a signed 16.16 coordinate into 0..1.0 by the active wrap mode.
    function automatic int unsigned fold_coord(logic [COORD_W-1:0] raw);
        if (cur_wrap == WRAP_REPEAT) return 32'(raw[15:0]);
        if (raw[31]) return 0;
        if (raw > 32'h0001_0000) return 32'h0001_0000;
        return raw;
    endfunction

    // Base texel, clamped neighbor and 8-bit weights of one sample.
    function automatic void locate_taps(input logic [COORD_W-1:0] u,
                                        input logic [COORD_W-1:0] v,
                                        output int unsigned x0, output int unsigned y0,
                                        output int unsigned x1, output int unsigned y1,
                                        output int unsigned wx, output int unsigned wy);
        int unsigned w;
        int unsigned h;
        int unsigned pu;
        int unsigned pv;
        w  = eff_dim(cur_width, STORE_W);
        h  = eff_dim(cur_height, STORE_H);
        pu = fold_coord(u) * (w - 1);
        pv = fold_coord(v) * (h - 1);
        x0 = pu >> 16;
        y0 = pv >> 16;
        x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
        wx = (pu & 32'hFFFF) >> 8;
        wy = (pv & 32'hFFFF) >> 8;
    endfunction

    // Color that a sample at (u, v) must return under the current settings.
    function automatic logic [TEXEL_W-1:0] sample_color(logic [COORD_W-1:0] u,
                                                       logic [COORD_W-1:0] v);
        int unsigned x0, y0, x1, y1, wx, wy;
        int unsigned c00, c10, c01, c11, top, bot;
        logic [TEXEL_W-1:0] s00, s10, s01, s11, mix;
        locate_taps(u, v, x0, y0, x1, y1, wx, wy);
        s00 = texel_mirror[y0 * STORE_W + x0];
        if (cur_filter == FILT_POINT) return s00;
        s10 = texel_mirror[y0 * STORE_W + x1];
        s01 = texel_mirror[y1 * STORE_W + x0];
        s11 = texel_mirror[y1 * STORE_W + x1];
        mix = '0;
        // Per channel: horizontal blend kept exact, then vertical with truncation.
        for (int ch = 0; ch < 4; ch++) begin
            c00 = 32'(s00[8*ch +: 8]);
            c10 = 32'(s10[8*ch +: 8]);
            c01 = 32'(s01[8*ch +: 8]);
            c11 = 32'(s11[8*ch +: 8]);
            top = c00 * (256 - wx) + c10 * wx;
            bot = c01 * (256 - wx) + c11 * wx;
            mix[8*ch +: 8] = 8'((top * (256 - wy) + bot * wy) >> 16);
        end
        return mix;
    endfunction

    function automatic void flag_mismatch(string what, logic [TEXEL_W-1:0] want,
                                          logic [TEXEL_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("Mismatch (%s): expected %08h, got %08h at %0t", what, want, got, $time);
    endfunction

    // Result checker: each color is matched with the oldest one owed.
    always @(posedge i_clk) begin
        logic [TEXEL_W-1:0] want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (color_due.size() == 0) begin
                flag_mismatch("unexpected color", '0, o_color_out);
            end else begin
                want = color_due.pop_front();
                compared_count++;
                if (o_color_out !== want) flag_mismatch("color", want, o_color_out);
            end
        end
    end

    // Present one transaction, with an optional random gap first, and wait
    // until the block takes it. The mirror is updated at acceptance.
    task automatic send_txn(t_req kind, logic [TXY_W-1:0] tx, logic [TXY_W-1:0] ty,
                            logic [TEXEL_W-1:0] texel, logic [COORD_W-1:0] u,
                            logic [COORD_W-1:0] v, logic fixed, logic [TEXEL_W-1:0] color);
        if (sender_gaps && $urandom_range(99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= kind;
        i_texel_x     <= tx;
        i_texel_y     <= ty;
        i_texel_value <= texel;
        i_u_coord     <= u;
        i_v_coord     <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_count++;
        if (kind == REQ_WRITE) begin
            texel_mirror[ty * STORE_W + tx] = texel;
            texel_set[ty * STORE_W + tx]    = 1'b1;
            write_count++;
        end else begin
            color_due.push_back(fixed ? color : sample_color(u, v));
            sample_count++;
        end
    endtask

    // Write random texels into any tap of a coming sample that was never
    // written, so that no sample reads an undefined entry.
    task automatic prime_taps(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned x0, y0, x1, y1, wx, wy;
        int unsigned xs [4];
        int unsigned ys [4];
        locate_taps(u, v, x0, y0, x1, y1, wx, wy);
        xs = '{x0, x1, x0, x1};
        ys = '{y0, y0, y1, y1};
        for (int k = 0; k < 4; k++) begin
            if (!texel_set[ys[k] * STORE_W + xs[k]])
                send_txn(REQ_WRITE, 7'(xs[k]), 7'(ys[k]), $urandom, $urandom, $urandom,
                         1'b0, '0);
        end
    endtask

    // Stop sending until every owed color has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (color_due.size() != 0) @(posedge i_clk);
    endtask

    // Write all four registers once the block is quiet.
    task automatic apply_settings(t_wrap wm, t_filter fm, logic [SIZE_W-1:0] wd,
                                  logic [SIZE_W-1:0] ht);
        wait_drained();
        repeat (10) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_WRAP;
        i_cfg_data  <= {7'($urandom), wm};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_FILTER;
        i_cfg_data  <= {7'($urandom), fm};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WIDTH;
        i_cfg_data  <= wd;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_HEIGHT;
        i_cfg_data  <= ht;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_wrap    = wm;
        cur_filter  = fm;
        cur_width   = wd;
        cur_height  = ht;
        settings_count++;
    endtask

    // Random size register value, weighted toward small textures.
    function automatic logic [SIZE_W-1:0] pick_dim();
        case ($urandom_range(4))
            0: return 8'($urandom_range(1, 4));
            1: return 8'($urandom_range(1, 128));
            2: return 8'd128;
            3: return ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(129, 255));
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    // Random 16.16 coordinate: raw words, values near 0..1, whole numbers
    // and the corners of the range.
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h0002_0000;
            2: return {16'($urandom), 16'h0000};
            3: begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'h0001_0000;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return {16'h0000, 16'($urandom)};
        endcase
    endfunction

    // Stimulus.
    initial begin
        int unsigned phase_base;
        int unsigned w;
        int unsigned h;
        logic [SIZE_W-1:0] wd;
        logic [SIZE_W-1:0] ht;
        t_wrap wm;
        t_filter fm;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        bit drained_mid;

        // Settle every input before the first edge.
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_req_type    <= REQ_WRITE;
        i_texel_x     <= '0;
        i_texel_y     <= '0;
        i_texel_value <= '0;
        i_u_coord     <= '0;
        i_v_coord     <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_idx     <= CFG_WRAP;
        i_cfg_data    <= '0;
        cur_wrap      = WRAP_CLAMP;
        cur_filter    = FILT_BILINEAR;
        cur_width     = RST_SIZE;
        cur_height    = RST_SIZE;
        sender_gaps   = 1'b1;
        drained_mid   = 1'b0;

        // Directed plan: reset settings first, then repeat, point and the
        // out-of-range size registers.
        directed_plan = '{
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_WRITE, 7'd0, 7'd0,
              32'h1122_3344, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_WRITE, 7'd1, 7'd0,
              32'hA0B0_C0D0, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_WRITE, 7'd0, 7'd1,
              32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_WRITE, 7'd1, 7'd1,
              32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_WRITE, 7'd127, 7'd127,
              32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0, 32'h0},
            // Origin, then negative coordinates that clamp to zero.
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1122_3344},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h8000_0000, 32'hFFFF_0000, 1'b1, 32'h1122_3344},
            // Exactly one and far beyond one land on the last texel.
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'hDEAD_BEEF},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h7FFF_FFFF, 32'h0002_0000, 1'b1, 32'hDEAD_BEEF},
            '{1'b0, WRAP_CLAMP, FILT_BILINEAR, 8'd0, 8'd0, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_0100, 32'h0000_0100, 1'b0, 32'h0},
            // Repeat on a 2x2 texture: half-way blend, whole numbers wrap to zero.
            '{1'b1, WRAP_REPEAT, FILT_BILINEAR, 8'd2, 8'd2, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_8000, 32'h0000_8000, 1'b0, 32'h0},
            '{1'b0, WRAP_REPEAT, FILT_BILINEAR, 8'd2, 8'd2, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'hFFFF_0000, 32'h0003_0000, 1'b1, 32'h1122_3344},
            '{1'b0, WRAP_REPEAT, FILT_BILINEAR, 8'd2, 8'd2, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
            // Width 0 acts as 1, height 255 as the full store.
            '{1'b1, WRAP_CLAMP, FILT_POINT, 8'd0, 8'd255, REQ_WRITE, 7'd0, 7'd127,
              32'h5A5A_A5A5, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_CLAMP, FILT_POINT, 8'd0, 8'd255, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h5A5A_A5A5},
            // Width 129 acts as the full store, height 1 pins the row.
            '{1'b1, WRAP_REPEAT, FILT_POINT, 8'd129, 8'd1, REQ_WRITE, 7'd126, 7'd0,
              32'h0102_0304, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_REPEAT, FILT_POINT, 8'd129, 8'd1, REQ_WRITE, 7'd127, 7'd0,
              32'hF0E0_D0C0, 32'h0, 32'h0, 1'b0, 32'h0},
            '{1'b0, WRAP_REPEAT, FILT_POINT, 8'd129, 8'd1, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_FFFF, 32'h1234_5678, 1'b1, 32'h0102_0304},
            '{1'b0, WRAP_REPEAT, FILT_POINT, 8'd129, 8'd1, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1122_3344},
            '{1'b1, WRAP_CLAMP, FILT_BILINEAR, 8'd128, 8'd128, REQ_SAMPLE, 7'd0, 7'd0,
              32'h0, 32'h0000_8000, 32'h0001_0000, 1'b0, 32'h0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].set_cfg)
                apply_settings(directed_plan[i].wrap, directed_plan[i].filt,
                               directed_plan[i].wd, directed_plan[i].ht);
            if (directed_plan[i].kind == REQ_SAMPLE)
                prime_taps(directed_plan[i].u, directed_plan[i].v);
            send_txn(directed_plan[i].kind, directed_plan[i].tx, directed_plan[i].ty,
                     directed_plan[i].texel, directed_plan[i].u, directed_plan[i].v,
                     directed_plan[i].fixed, directed_plan[i].color);
        end

        // Random phases. The first four cover every mode pair at extreme sizes.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin wd = 8'd1;   ht = 8'd128; end
                1: begin wd = 8'd128; ht = 8'd1;   end
                2: begin wd = 8'd0;   ht = 8'd255; end
                3: begin wd = 8'd2;   ht = 8'd2;   end
                default: begin wd = pick_dim(); ht = pick_dim(); end
            endcase
            if (p < 4) begin
                wm = t_wrap'(p[0]);
                fm = t_filter'(p[1]);
            end else begin
                wm = t_wrap'($urandom_range(1));
                fm = t_filter'($urandom_range(1));
            end
            apply_settings(wm, fm, wd, ht);
            w = eff_dim(wd, STORE_W);
            h = eff_dim(ht, STORE_H);
            // A long run of back-to-back transactions.
            sender_gaps = !(p == 5 || p == 6);
            phase_base  = sent_count;
            while (sent_count - phase_base < PHASE_ITEMS) begin
                if (p == 4 && !drained_mid && sent_count - phase_base >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    drained_mid = 1'b1;
                end
                if ($urandom_range(99) < 35) begin
                    if ($urandom_range(99) < 80)
                        send_txn(REQ_WRITE, 7'($urandom_range(0, w - 1)),
                                 7'($urandom_range(0, h - 1)), $urandom, $urandom, $urandom,
                                 1'b0, '0);
                    else
                        send_txn(REQ_WRITE, 7'($urandom), 7'($urandom), $urandom, $urandom,
                                 $urandom, 1'b0, '0);
                end else begin
                    u = pick_coord();
                    v = pick_coord();
                    prime_taps(u, v);
                    send_txn(REQ_SAMPLE, 7'($urandom), 7'($urandom), $urandom, u, v, 1'b0, '0);
                end
            end
        end

        // Let the last colors come back, then a margin for any stray output.
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (color_due.size() != 0) begin
            fail_count += color_due.size();
            $display("%0d colors never arrived", color_due.size());
        end
        $display("Ran %0d texel writes and %0d samples under %0d register settings.",
                 write_count, sample_count, settings_count);
        $display("Compared %0d colors, %0d mismatches.", compared_count, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
